[sv/ssas_pkg.sv]
`default_nettype none
package ssas_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W = 31;
    localparam int VEC_W = 32;

    localparam logic [2:0] OP_PLACE  = 3'd0;
    localparam logic [2:0] OP_TARGET = 3'd1;
    localparam logic [2:0] OP_SEEK   = 3'd2;
    localparam logic [2:0] OP_ARRIVE = 3'd3;
    localparam logic [2:0] OP_PROC   = 3'd4;

    localparam logic CFG_MAX_SPEED = 1'b0;
    localparam logic CFG_MAX_FORCE = 1'b1;

    localparam logic [CFG_W-1:0] MAX_SPEED_RST = 31'd65536;
    localparam logic [CFG_W-1:0] MAX_FORCE_RST = 31'd6554;
    localparam logic [31:0] ARRIVE_DIV = 32'd10;
    // Reciprocal of ten; the product shifted right by RECIP10_SHIFT is the exact
    // floor of a 32-bit value divided by ten.
    localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
    localparam int RECIP10_SHIFT = 35;

    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_DIFF     = 22'h000002,
        S_SQ_MUL   = 22'h000004,
        S_SQ_ACC   = 22'h000008,
        S_SQRT     = 22'h000010,
        S_SPEED    = 22'h000020,
        S_ARR_CMP  = 22'h000040,
        S_SPD_DONE = 22'h000080,
        S_DES      = 22'h000100,
        S_DES_DIV  = 22'h000200,
        S_DES_FIN  = 22'h000400,
        S_CAP      = 22'h000800,
        S_CAP2     = 22'h001000,
        S_LIM      = 22'h002000,
        S_LSC_MUL  = 22'h004000,
        S_LSC_DIV  = 22'h008000,
        S_LSC_FIN  = 22'h010000,
        S_LIM_DONE = 22'h020000,
        S_PROC     = 22'h040000,
        S_PROC2    = 22'h080000,
        S_DIV      = 22'h100000,
        S_OUT      = 22'h200000
    } state_t;

    typedef logic signed [VEC_W-1:0] vec_t [3];

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [31:0] r;
        r = x[31] ? 32'(-x) : 32'(x);
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/steering_seek_arrive_step_unit.sv]
`default_nettype none
// Steering agent with seek and arrive behavior in signed fixed point.
// Input transfers on the s_ group carry one vector in s_tdata and the
// operation in s_tuser; each accepted transfer yields exactly one output
// transfer on the m_ group with the agent position and its enable flag.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and must be written only while the block is idle.
// Place, set target and unused operations go straight to the output state.
// Process, seek and arrive use the 32-step square root and the single shared
// 32 by 32 multiplier, and seek and arrive also the shared 64-step serial
// divider (one quotient bit per cycle), all run under one sequencer;
// s_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next input transfer can be
// taken while it waits; a stalled receiver holds the sequencer in its final
// state until the register frees. Reset clears position, velocity and target,
// sets the enable flag and loads the default speed and force limits.
module steering_seek_arrive_step_unit #(
    parameter int FRAC_BITS = ssas_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // vec_x [31:0], vec_y [63:32], vec_z [95:64]
    input  wire logic [95:0]                s_tdata,
    // operation [2:0]
    input  wire logic [2:0]                 s_tuser,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    output logic [95:0]                     m_tdata,
    // active [0]
    output logic [0:0]                      m_tuser,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [ssas_pkg::CFG_W-1:0] cfg_data
);
    import ssas_pkg::*;

    localparam logic [63:0] ONE_FIX = 64'd1 << FRAC_BITS;

    state_t state_reg, len_ret_reg, div_ret_reg;
    logic [2:0] op_reg;
    logic [1:0] idx_reg;
    logic [5:0] cnt_reg;
    logic lim_vel_reg, en_reg;
    logic [CFG_W-1:0] ms_reg, mf_reg;
    vec_t pos_reg, vel_reg, goal_reg, vin_reg, dv_reg, w_reg;
    logic [31:0] len_reg, speed_reg;
    logic [63:0] cap_reg, acc_reg, mul_reg;
    logic [63:0] sq_n_reg, sq_root_reg, sq_bit_reg;
    logic [63:0] dv_num_reg;
    logic [32:0] dv_rem_reg;
    logic [31:0] dv_den_reg;
    logic out_valid_reg;
    logic [95:0] out_data_reg;
    logic out_act_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] sq_t;
    logic [32:0] dv_rs;
    logic dv_ge;
    logic signed [65:0] des_val;
    logic close;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_act_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQ_MUL:
            begin
                mul_a = mag32(w_reg[idx_reg]);
                mul_b = mag32(w_reg[idx_reg]);
            end
            S_SPEED:
            begin
                mul_a = {1'b0, ms_reg};
                mul_b = ARRIVE_DIV;
            end
            S_ARR_CMP:
            begin
                mul_a = len_reg;
                mul_b = RECIP10;
            end
            S_DES:
            begin
                mul_a = mag32(dv_reg[idx_reg]);
                mul_b = speed_reg;
            end
            S_CAP:
            begin
                mul_a = {1'b0, mf_reg};
                mul_b = {1'b0, ms_reg};
            end
            S_LSC_MUL:
            begin
                mul_a = mag32(w_reg[idx_reg]);
                mul_b = cap_reg[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sq_t  = sq_root_reg + sq_bit_reg;
    assign dv_rs = {dv_rem_reg[31:0], dv_num_reg[63]};
    assign dv_ge = (dv_rs >= {1'b0, dv_den_reg});
    assign des_val = dv_reg[idx_reg][31] ? -$signed({2'b00, dv_num_reg})
                                         : $signed({2'b00, dv_num_reg});
    assign close = ({32'd0, len_reg} < ONE_FIX);

    always_ff @(posedge clk)
    begin
        mul_reg <= 64'(mul_a * mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_ret_reg   <= S_IDLE;
            div_ret_reg   <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            lim_vel_reg   <= 1'b0;
            en_reg        <= 1'b1;
            ms_reg        <= MAX_SPEED_RST;
            mf_reg        <= MAX_FORCE_RST;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                goal_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_SPEED: ms_reg <= cfg_data;
                    CFG_MAX_FORCE: mf_reg <= cfg_data;
                endcase
            end
            if (out_valid_reg && m_tready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg <= s_tuser;
                        for (int i = 0; i < 3; i++)
                            vin_reg[i] <= s_tdata[32*i +: 32];
                        if (s_tuser == OP_PLACE)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                pos_reg[i] <= s_tdata[32*i +: 32];
                                vel_reg[i] <= '0;
                            end
                            en_reg    <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (s_tuser == OP_TARGET)
                        begin
                            for (int i = 0; i < 3; i++)
                                goal_reg[i] <= s_tdata[32*i +: 32];
                            state_reg <= S_OUT;
                        end
                        else if (s_tuser == OP_SEEK || s_tuser == OP_ARRIVE)
                            state_reg <= S_DIFF;
                        else if (s_tuser == OP_PROC)
                            state_reg <= S_PROC;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        logic signed [31:0] d;
                        d = sat32(66'(op_reg == OP_SEEK ? vin_reg[i] : goal_reg[i])
                                  - 66'(pos_reg[i]));
                        dv_reg[i] <= d;
                        w_reg[i]  <= d;
                    end
                    acc_reg     <= '0;
                    idx_reg     <= '0;
                    len_ret_reg <= S_SPEED;
                    state_reg   <= S_SQ_MUL;
                end
                S_SQ_MUL:
                    state_reg <= S_SQ_ACC;
                S_SQ_ACC:
                begin
                    acc_reg <= acc_reg + mul_reg;
                    if (idx_reg == 2'd2)
                    begin
                        sq_n_reg    <= acc_reg + mul_reg;
                        sq_root_reg <= '0;
                        sq_bit_reg  <= 64'd1 << 62;
                        cnt_reg     <= '0;
                        state_reg   <= S_SQRT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_SQRT:
                begin
                    if (sq_n_reg >= sq_t)
                    begin
                        sq_n_reg    <= sq_n_reg - sq_t;
                        sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_root_reg <= sq_root_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                    begin
                        len_reg   <= (sq_n_reg >= sq_t) ? 32'((sq_root_reg >> 1) + sq_bit_reg)
                                                        : 32'(sq_root_reg >> 1);
                        state_reg <= len_ret_reg;
                    end
                end
                S_SPEED:
                begin
                    idx_reg <= '0;
                    if (op_reg == OP_SEEK)
                    begin
                        speed_reg <= {1'b0, ms_reg};
                        state_reg <= S_DES;
                    end
                    else
                        state_reg <= S_ARR_CMP;
                end
                S_ARR_CMP:
                begin
                    if ({32'd0, len_reg} < mul_reg)
                        state_reg <= S_SPD_DONE;
                    else
                    begin
                        speed_reg <= {1'b0, ms_reg};
                        state_reg <= S_DES;
                    end
                end
                S_SPD_DONE:
                begin
                    speed_reg <= 32'(mul_reg >> RECIP10_SHIFT);
                    state_reg <= S_DES;
                end
                S_DES:
                begin
                    if (len_reg == '0)
                    begin
                        w_reg[idx_reg] <= sat32(66'sd0 - 66'(vel_reg[idx_reg]));
                        if (idx_reg == 2'd2)
                            state_reg <= S_CAP;
                        else
                            idx_reg <= idx_reg + 2'd1;
                    end
                    else
                        state_reg <= S_DES_DIV;
                end
                S_DES_DIV:
                begin
                    dv_num_reg  <= mul_reg;
                    dv_den_reg  <= len_reg;
                    dv_rem_reg  <= '0;
                    cnt_reg     <= '0;
                    div_ret_reg <= S_DES_FIN;
                    state_reg   <= S_DIV;
                end
                S_DES_FIN:
                begin
                    w_reg[idx_reg] <= sat32(des_val - 66'(vel_reg[idx_reg]));
                    if (idx_reg == 2'd2)
                        state_reg <= S_CAP;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_DES;
                    end
                end
                S_CAP:
                begin
                    lim_vel_reg <= 1'b0;
                    acc_reg     <= '0;
                    idx_reg     <= '0;
                    len_ret_reg <= S_LIM;
                    if (op_reg == OP_SEEK)
                    begin
                        cap_reg   <= {33'd0, mf_reg};
                        state_reg <= S_SQ_MUL;
                    end
                    else
                        state_reg <= S_CAP2;
                end
                S_CAP2:
                begin
                    cap_reg   <= mul_reg >> FRAC_BITS;
                    state_reg <= S_SQ_MUL;
                end
                S_LIM:
                begin
                    idx_reg <= '0;
                    if ({32'd0, len_reg} > cap_reg)
                        state_reg <= S_LSC_MUL;
                    else
                        state_reg <= S_LIM_DONE;
                end
                S_LSC_MUL:
                    state_reg <= S_LSC_DIV;
                S_LSC_DIV:
                begin
                    dv_num_reg  <= mul_reg;
                    dv_den_reg  <= len_reg;
                    dv_rem_reg  <= '0;
                    cnt_reg     <= '0;
                    div_ret_reg <= S_LSC_FIN;
                    state_reg   <= S_DIV;
                end
                S_LSC_FIN:
                begin
                    w_reg[idx_reg] <= w_reg[idx_reg][31] ? 32'(-dv_num_reg[31:0])
                                                         : dv_num_reg[31:0];
                    if (idx_reg == 2'd2)
                        state_reg <= S_LIM_DONE;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_LSC_MUL;
                    end
                end
                S_LIM_DONE:
                begin
                    if (!lim_vel_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                            w_reg[i] <= sat32(66'(vel_reg[i]) + 66'(w_reg[i]));
                        cap_reg     <= {33'd0, ms_reg};
                        lim_vel_reg <= 1'b1;
                        acc_reg     <= '0;
                        idx_reg     <= '0;
                        len_ret_reg <= S_LIM;
                        state_reg   <= S_SQ_MUL;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            vel_reg[i] <= w_reg[i];
                            pos_reg[i] <= sat32(66'(pos_reg[i]) + 66'(w_reg[i]));
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_PROC:
                begin
                    for (int i = 0; i < 3; i++)
                        w_reg[i] <= sat32(66'(pos_reg[i]) - 66'(goal_reg[i]));
                    acc_reg     <= '0;
                    idx_reg     <= '0;
                    len_ret_reg <= S_PROC2;
                    state_reg   <= S_SQ_MUL;
                end
                S_PROC2:
                begin
                    if (close)
                    begin
                        en_reg <= 1'b0;
                        for (int i = 0; i < 3; i++)
                            goal_reg[i] <= vin_reg[i];
                    end
                    if (close || !en_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                            pos_reg[i] <= vin_reg[i];
                    end
                    state_reg <= S_OUT;
                end
                S_DIV:
                begin
                    dv_rem_reg <= dv_ge ? 33'(dv_rs - {1'b0, dv_den_reg}) : dv_rs;
                    dv_num_reg <= {dv_num_reg[62:0], dv_ge};
                    cnt_reg    <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= div_ret_reg;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {pos_reg[2], pos_reg[1], pos_reg[0]};
                        out_act_reg   <= en_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_seek_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_SEEK) |=> (state_reg == S_DIFF))
        else $error("seek did not start the difference step");

    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> $onehot(sq_bit_reg))
        else $error("square root bit lost");

    a_limit_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LSC_MUL) |-> ({32'd0, len_reg} > cap_reg))
        else $error("limit scaling without excess length");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !m_tready) |=> (state_reg == S_OUT))
        else $error("result dropped while output stalled");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

import ssas_pkg::*;

typedef struct {
    logic [31:0] pos [3];
    logic        active;
} agent_report_t;

class agent_scoreboard;
    longint          pos [3];
    longint          vel [3];
    longint          goal [3];
    bit              en;
    longint unsigned speed_cap;
    longint unsigned force_cap;
    agent_report_t   pending_q [$];
    int              errors;
    int              checked;

    function new();
        for (int i = 0; i < 3; i++)
        begin
            pos[i] = 0;
            vel[i] = 0;
            goal[i] = 0;
        end
        en = 1'b1;
        speed_cap = 65536;
        force_cap = 6554;
        errors = 0;
        checked = 0;
    endfunction

    function longint clip32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function longint unsigned absval(longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    function longint unsigned root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function longint unsigned length3(longint v [3]);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < 3; i++)
            s += absval(v[i]) * absval(v[i]);
        return root(s);
    endfunction

    function longint rescale(longint x, longint unsigned num, longint unsigned den);
        longint unsigned m;
        m = absval(x) * num / den;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function void clamp_len(inout longint v [3], input longint unsigned cap);
        longint unsigned len;
        len = length3(v);
        if (len > cap)
            for (int i = 0; i < 3; i++)
                v[i] = rescale(v[i], cap, len);
    endfunction

    function void steer(longint p [3], bit arriving);
        longint          d [3];
        longint          st [3];
        longint          want;
        longint unsigned len;
        longint unsigned spd;
        longint unsigned cap;
        for (int i = 0; i < 3; i++)
            d[i] = clip32(p[i] - pos[i]);
        len = length3(d);
        spd = speed_cap;
        if (arriving && len < speed_cap * 10)
            spd = len / 10;
        cap = arriving ? (force_cap * speed_cap) >> FRAC_BITS_DEF : force_cap;
        for (int i = 0; i < 3; i++)
        begin
            want = len != 0 ? rescale(d[i], spd, len) : 0;
            st[i] = clip32(want - vel[i]);
        end
        clamp_len(st, cap);
        for (int i = 0; i < 3; i++)
            vel[i] = clip32(vel[i] + st[i]);
        clamp_len(vel, speed_cap);
        for (int i = 0; i < 3; i++)
            pos[i] = clip32(pos[i] + vel[i]);
    endfunction

    function void set_limits(bit idx, logic [CFG_W-1:0] val);
        if (idx == CFG_MAX_SPEED)
            speed_cap = val;
        else
            force_cap = val;
    endfunction

    function void note_input(logic [2:0] op, logic [31:0] vec [3]);
        longint        v [3];
        longint        d [3];
        agent_report_t r;
        for (int i = 0; i < 3; i++)
            v[i] = longint'(signed'(vec[i]));
        case (op)
            OP_PLACE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos[i] = v[i];
                    vel[i] = 0;
                end
                en = 1'b1;
            end
            OP_TARGET:
                for (int i = 0; i < 3; i++)
                    goal[i] = v[i];
            OP_SEEK:
                steer(v, 1'b0);
            OP_ARRIVE:
                steer(goal, 1'b1);
            OP_PROC:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = clip32(pos[i] - goal[i]);
                if (length3(d) < (64'd1 << FRAC_BITS_DEF))
                begin
                    en = 1'b0;
                    for (int i = 0; i < 3; i++)
                        goal[i] = v[i];
                end
                if (!en)
                    for (int i = 0; i < 3; i++)
                        pos[i] = v[i];
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 3; i++)
            r.pos[i] = pos[i][31:0];
        r.active = en;
        pending_q.push_back(r);
    endfunction

    function void check_result(logic [95:0] data, logic [0:0] user);
        agent_report_t r;
        checked++;
        if (pending_q.size() == 0)
        begin
            $error("unexpected result transfer: data %h active %b", data, user);
            errors++;
            return;
        end
        r = pending_q.pop_front();
        for (int i = 0; i < 3; i++)
            if (data[32*i +: 32] !== r.pos[i])
            begin
                $error("pos_%0d mismatch: expected %h actual %h", i, r.pos[i],
                    data[32*i +: 32]);
                errors++;
            end
        if (user[0] !== r.active)
        begin
            $error("active mismatch: expected %b actual %b", r.active, user[0]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [95:0]          s_tdata;
    logic [2:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [95:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    agent_scoreboard sb;
    int              op_count [8];
    int              cfg_count;
    bit              no_gaps;

    steering_seek_arrive_step_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    task automatic send_item(logic [2:0] op, logic [31:0] vec [3]);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {vec[2], vec[1], vec[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(op, vec);
        op_count[op]++;
    endtask

    task automatic write_limit(bit idx, logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limits(idx, val);
        cfg_count++;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            2: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($urandom_range(0, 32'h0000_8000)) - 32'h0000_4000;
        endcase
    endfunction

    function automatic void rand_vec(output logic [31:0] v [3], input int mode);
        for (int i = 0; i < 3; i++)
            v[i] = rand_coord(mode);
    endfunction

    function automatic void near_pos(output logic [31:0] v [3]);
        for (int i = 0; i < 3; i++)
            v[i] = sb.pos[i][31:0] + rand_coord(3);
    endfunction

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        #60000000;
        $display("** steering_seek_arrive_step_unit: FAILED **");
        $finish;
    end

    initial
    begin
        logic [31:0] v [3];
        int          sent;
        int          mode;
        int          kind;
        logic [CFG_W-1:0] spd;
        logic [CFG_W-1:0] frc;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        no_gaps = 1'b0;
        cfg_count = 0;
        for (int i = 0; i < 8; i++)
            op_count[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        v = '{32'h0, 32'h0, 32'h0};
        send_item(OP_SEEK, v);
        send_item(OP_ARRIVE, v);
        send_item(OP_PROC, v);
        v = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        send_item(OP_PLACE, v);
        v = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
        send_item(OP_SEEK, v);
        send_item(OP_TARGET, v);
        send_item(OP_ARRIVE, v);
        send_item(OP_ARRIVE, v);
        v = '{32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
        send_item(OP_PLACE, v);
        send_item(OP_TARGET, v);
        send_item(OP_SEEK, v);
        near_pos(v);
        send_item(OP_TARGET, v);
        v = '{32'h0050_0000, 32'h0, 32'hffff_ffff};
        send_item(OP_PROC, v);
        send_item(OP_ARRIVE, v);
        send_item(OP_PROC, v);
        send_item(3'd5, v);
        send_item(3'd6, v);
        send_item(3'd7, v);
        v = '{32'h0, 32'h0, 32'h0};
        send_item(OP_PLACE, v);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin spd = 31'd65536; frc = 31'd6554; end
                1: begin spd = 31'd0; frc = 31'd6554; end
                2: begin spd = 31'h7fff_ffff; frc = 31'h7fff_ffff; end
                3: begin spd = 31'd65536; frc = 31'd0; end
                4: begin spd = 31'h7fff_ffff; frc = 31'd0; end
                5: begin spd = 31'd0; frc = 31'h7fff_ffff; end
                default:
                begin
                    spd = ($urandom_range(0, 1) != 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h40000));
                    frc = ($urandom_range(0, 1) != 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h40000));
                end
            endcase
            write_limit(CFG_MAX_SPEED, spd);
            write_limit(CFG_MAX_FORCE, frc);
            sent = 0;
            while (sent < 240)
            begin
                no_gaps = ($urandom_range(0, 7) == 0);
                kind = $urandom_range(0, 9);
                mode = $urandom_range(0, 3) == 0 ? 0 : 1;
                if (kind < 8)
                begin
                    rand_vec(v, mode);
                    send_item(OP_PLACE, v);
                    if ($urandom_range(0, 1) != 0)
                        near_pos(v);
                    else
                        rand_vec(v, mode);
                    send_item(OP_TARGET, v);
                    sent += 2;
                    for (int k = $urandom_range(1, 4); k > 0; k--)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            rand_vec(v, mode);
                            send_item(OP_SEEK, v);
                        end
                        else
                            send_item(OP_ARRIVE, v);
                        sent++;
                    end
                    if ($urandom_range(0, 1) != 0)
                    begin
                        near_pos(v);
                        send_item(OP_TARGET, v);
                        sent++;
                    end
                    rand_vec(v, mode);
                    send_item(OP_PROC, v);
                    send_item(OP_ARRIVE, v);
                    send_item(OP_PROC, v);
                    sent += 3;
                end
                else
                begin
                    rand_vec(v, $urandom_range(0, 3));
                    send_item(3'($urandom_range(0, 7)), v);
                    sent++;
                end
            end
        end

        s_tvalid <= 1'b0;
        no_gaps = 1'b0;
        while (sb.pending_q.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.pending_q.size() > 0)
        begin
            $error("%0d expected results never arrived", sb.pending_q.size());
            sb.errors++;
        end
        $display("Covered %0d results over %0d limit writes; place %0d target %0d seek %0d",
            sb.checked, cfg_count, op_count[OP_PLACE], op_count[OP_TARGET],
            op_count[OP_SEEK]);
        $display("arrive %0d process %0d no-op %0d", op_count[OP_ARRIVE],
            op_count[OP_PROC], op_count[5] + op_count[6] + op_count[7]);
        if (sb.errors == 0)
            $display("** steering_seek_arrive_step_unit: PASSED **");
        else
            $display("** steering_seek_arrive_step_unit: FAILED **");
        $finish;
    end
endmodule
